// ===== src/tbd_pkg.sv =====
// Shared types and constants for the tunnel brightness detector.
// No dependencies; used by every module in src.
package tbd_pkg;

    localparam int PIX_W   = 8;
    localparam int PROD_W  = 22;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 16;
    localparam int PCT_W   = 7;
    localparam int LIM_W   = 6;
    localparam int DCNT_W  = 7;
    localparam int SCALE_W = 15;
    localparam int CMP_W   = 31;
    localparam int IDX_W   = 2;

    // fixed-point gray weights, sum of weights is 1 << GRAY_SHIFT
    localparam logic [PROD_W-1:0] WEIGHT_R   = 22'd4899;
    localparam logic [PROD_W-1:0] WEIGHT_G   = 22'd9617;
    localparam logic [PROD_W-1:0] WEIGHT_B   = 22'd1868;
    localparam logic [PROD_W-1:0] GRAY_ROUND = 22'd8192;
    localparam int GRAY_SHIFT = 14;

    localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
    localparam logic [SCALE_W-1:0] PIX_FULL  = 15'd255;
    localparam logic [CMP_W-1:0]   PCT_SCALE = 31'd100;

    localparam logic [PCT_W-1:0] RST_DARK_PERCENT    = 7'd50;
    localparam logic [LIM_W-1:0] RST_COUNT_LIMIT     = 6'd20;
    localparam logic [LIM_W-1:0] RST_ENTER_THRESHOLD = 6'd10;
    localparam logic signed [DCNT_W-1:0] RST_DARK_COUNT = -7'sd1;

    localparam logic [IDX_W-1:0] REG_DARK_PERCENT    = 2'd0;
    localparam logic [IDX_W-1:0] REG_COUNT_LIMIT     = 2'd1;
    localparam logic [IDX_W-1:0] REG_ENTER_THRESHOLD = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_frame;

    typedef struct packed {
        logic [PCT_W-1:0] dark_percent;
        logic [LIM_W-1:0] count_limit;
        logic [LIM_W-1:0] enter_threshold;
    } t_cfg;

endpackage

// ===== src/tbd_front.sv =====
// Front end: pixel positions, sampling grid, gray conversion and frame sums.
// Uses tbd_pkg; pushes one frame record into tbd_queue per frame end.
module tbd_front #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_STEP = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tbd_pkg::PIX_W-1:0]     i_red,
    input  logic [tbd_pkg::PIX_W-1:0]     i_green,
    input  logic [tbd_pkg::PIX_W-1:0]     i_blue,
    input  logic                          i_last_in_line,
    input  logic                          i_last_in_frame,
    input  logic [tbd_pkg::QLVL_W-1:0]    i_q_level,
    output logic                          o_q_push,
    output tbd_pkg::t_frame               o_q_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PH_W  = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);
    localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(SAMPLE_STEP - 1);
    localparam int OCC_W = tbd_pkg::QLVL_W + 1;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PH_W-1:0]  r_col_ph, n_col_ph;
    logic [PH_W-1:0]  r_row_ph, n_row_ph;

    logic                         r_a_valid, r_a_eof, r_a_sample;
    logic [tbd_pkg::PROD_W-1:0]   r_a_prod_r, r_a_prod_g, r_a_prod_b;
    logic                         r_b_valid, r_b_eof, r_b_sample;
    logic [tbd_pkg::PIX_W-1:0]    r_b_gray;
    logic [tbd_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [tbd_pkg::CNT_W-1:0]    r_cnt, n_cnt;

    logic                         accept;
    logic [tbd_pkg::PROD_W-1:0]   gray_full;
    logic [tbd_pkg::SUM_W:0]      sum_wide;
    logic [OCC_W-1:0]             occ;

    // every frame end already in the pipe holds a queue slot
    assign occ = OCC_W'(i_q_level) + OCC_W'(r_a_valid & r_a_eof)
               + OCC_W'(r_b_valid & r_b_eof);
    assign o_stall = (occ >= OCC_W'(tbd_pkg::QUEUE_DEPTH));
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_col_ph = r_col_ph;
        n_row_ph = r_row_ph;
        if (i_last_in_frame) begin
            n_col    = '0;
            n_row    = '0;
            n_col_ph = '0;
            n_row_ph = '0;
        end else if (i_last_in_line) begin
            n_col    = '0;
            n_col_ph = '0;
            if (r_row < ROW_LAST) begin
                n_row    = r_row + 1'b1;
                n_row_ph = (r_row_ph == PH_LAST) ? '0 : r_row_ph + 1'b1;
            end
        end else if (r_col < COL_LAST) begin
            n_col    = r_col + 1'b1;
            n_col_ph = (r_col_ph == PH_LAST) ? '0 : r_col_ph + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
        end else if (accept) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_col_ph <= n_col_ph;
            r_row_ph <= n_row_ph;
        end
    end

    // stage A: weighted products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_eof    <= i_last_in_frame;
        r_a_sample <= (r_col_ph == '0) && (r_row_ph == '0);
        r_a_prod_r <= tbd_pkg::PROD_W'(i_red) * tbd_pkg::WEIGHT_R;
        r_a_prod_g <= tbd_pkg::PROD_W'(i_green) * tbd_pkg::WEIGHT_G;
        r_a_prod_b <= tbd_pkg::PROD_W'(i_blue) * tbd_pkg::WEIGHT_B;
    end

    // stage B: rounded gray value
    assign gray_full = r_a_prod_r + r_a_prod_g + r_a_prod_b + tbd_pkg::GRAY_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_eof    <= r_a_eof;
        r_b_sample <= r_a_sample;
        r_b_gray   <= gray_full[tbd_pkg::PROD_W-1:tbd_pkg::GRAY_SHIFT];
    end

    // accumulate, saturating
    assign sum_wide = {1'b0, r_sum} + (tbd_pkg::SUM_W+1)'(r_b_gray);

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (r_b_valid && r_b_sample) begin
            n_sum = sum_wide[tbd_pkg::SUM_W] ? '1 : sum_wide[tbd_pkg::SUM_W-1:0];
            if (r_cnt != '1) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    assign o_q_push       = r_b_valid & r_b_eof;
    assign o_q_data.sum   = n_sum;
    assign o_q_data.count = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (o_q_push) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== src/tbd_queue.sv =====
// Small FIFO of finished frame records between front and back.
// Uses tbd_pkg for the record type and depth.
module tbd_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  tbd_pkg::t_frame             i_data,
    input  logic                        i_pop,
    output logic                        o_valid,
    output tbd_pkg::t_frame             o_data,
    output logic [tbd_pkg::QLVL_W-1:0]  o_level
);

    tbd_pkg::t_frame                 r_mem [tbd_pkg::QUEUE_DEPTH];
    logic [tbd_pkg::QPTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [tbd_pkg::QLVL_W-1:0]      r_level;

    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

// ===== src/tbd_back.sv =====
// Back end: frame darkness decision, dark counter and result register.
// Uses tbd_pkg; pops frame records from tbd_queue.
module tbd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tbd_pkg::t_cfg                      i_cfg,
    input  logic                               i_q_valid,
    input  tbd_pkg::t_frame                    i_q_data,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_in_tunnel,
    output logic                               o_frame_dark,
    output logic signed [tbd_pkg::DCNT_W-1:0]  o_dark_count
);

    logic [tbd_pkg::SCALE_W-1:0]          r_scale;
    logic                                 r_m_valid;
    logic [tbd_pkg::CMP_W-1:0]            r_lhs, r_rhs;
    logic signed [tbd_pkg::DCNT_W-1:0]    r_counter, n_counter;
    logic                                 r_out_valid, r_out_tunnel, r_out_dark;
    logic signed [tbd_pkg::DCNT_W-1:0]    r_out_count;

    logic                                 out_free, m_move, dark;
    logic signed [tbd_pkg::DCNT_W-1:0]    limit_s, thresh_s;

    // (100 - percent) * 255, zero when percent is above 100 (never dark)
    always_ff @(posedge i_clk) begin
        if (i_cfg.dark_percent > tbd_pkg::PCT_FULL) begin
            r_scale <= '0;
        end else begin
            r_scale <= tbd_pkg::SCALE_W'(tbd_pkg::PCT_FULL - i_cfg.dark_percent)
                     * tbd_pkg::PIX_FULL;
        end
    end

    assign out_free = ~r_out_valid | ~i_stall;
    assign m_move   = r_m_valid & out_free;
    assign o_q_pop  = i_q_valid & (~r_m_valid | out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (~r_m_valid | out_free) begin
            r_m_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_lhs <= tbd_pkg::CMP_W'(i_q_data.sum) * tbd_pkg::PCT_SCALE;
            r_rhs <= tbd_pkg::CMP_W'(i_q_data.count) * tbd_pkg::CMP_W'(r_scale);
        end
    end

    assign dark     = (r_lhs < r_rhs);
    assign limit_s  = $signed({1'b0, i_cfg.count_limit});
    assign thresh_s = $signed({1'b0, i_cfg.enter_threshold});

    always_comb begin
        n_counter = r_counter;
        if (dark) begin
            if (r_counter < limit_s) begin
                n_counter = r_counter + 7'sd1;
            end
        end else if (r_counter > 7'sd0) begin
            n_counter = r_counter - 7'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= tbd_pkg::RST_DARK_COUNT;
            r_out_valid <= 1'b0;
        end else begin
            if (m_move) begin
                r_counter <= n_counter;
            end
            if (out_free) begin
                r_out_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_move) begin
            r_out_tunnel <= (n_counter >= thresh_s);
            r_out_dark   <= dark;
            r_out_count  <= n_counter;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_in_tunnel  = r_out_tunnel;
    assign o_frame_dark = r_out_dark;
    assign o_dark_count = r_out_count;

endmodule

// ===== src/tunnel_brightness_detector.sv =====
// Top level of the tunnel brightness detector: config registers and wiring.
// Uses tbd_pkg, tbd_front, tbd_queue and tbd_back.
//
//  port group     direction  handshake                 payload
//  pixel in       in         i_valid / o_stall         i_red i_green i_blue
//                                                      i_last_in_line i_last_in_frame
//  frame result   out        o_valid / i_stall         o_in_tunnel o_frame_dark
//                                                      o_dark_count
//  config write   in         i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// One pixel per cycle while o_stall is low. A frame result passes, after its last pixel,
// through products, gray, queue, compare multiplies and result register.
// Pixels stall only while the four-entry frame queue is full counting frame ends
// still in the front pipe. Reset is synchronous; no clearing pass.
module tunnel_brightness_detector #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_STEP = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [tbd_pkg::PIX_W-1:0]          i_red,
    input  logic [tbd_pkg::PIX_W-1:0]          i_green,
    input  logic [tbd_pkg::PIX_W-1:0]          i_blue,
    input  logic                               i_last_in_line,
    input  logic                               i_last_in_frame,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_in_tunnel,
    output logic                               o_frame_dark,
    output logic signed [tbd_pkg::DCNT_W-1:0]  o_dark_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tbd_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [tbd_pkg::PCT_W-1:0]          i_cfg_data
);

    tbd_pkg::t_cfg                  r_cfg;
    logic                           q_push, q_pop, q_valid;
    tbd_pkg::t_frame                q_in, q_out;
    logic [tbd_pkg::QLVL_W-1:0]     q_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_percent    <= tbd_pkg::RST_DARK_PERCENT;
            r_cfg.count_limit     <= tbd_pkg::RST_COUNT_LIMIT;
            r_cfg.enter_threshold <= tbd_pkg::RST_ENTER_THRESHOLD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tbd_pkg::REG_DARK_PERCENT: begin
                    r_cfg.dark_percent <= i_cfg_data;
                end
                tbd_pkg::REG_COUNT_LIMIT: begin
                    r_cfg.count_limit <= i_cfg_data[tbd_pkg::LIM_W-1:0];
                end
                tbd_pkg::REG_ENTER_THRESHOLD: begin
                    r_cfg.enter_threshold <= i_cfg_data[tbd_pkg::LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tbd_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_STEP (SAMPLE_STEP)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_last_in_line  (i_last_in_line),
        .i_last_in_frame (i_last_in_frame),
        .i_q_level       (q_level),
        .o_q_push        (q_push),
        .o_q_data        (q_in)
    );

    tbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_level (q_level)
    );

    tbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_data     (q_out),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_in_tunnel  (o_in_tunnel),
        .o_frame_dark (o_frame_dark),
        .o_dark_count (o_dark_count)
    );

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_level < tbd_pkg::QLVL_W'(tbd_pkg::QUEUE_DEPTH)) || q_pop)
        else $error("frame queue overflow");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("frame queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dark_count >= -7'sd1))
        else $error("dark count below minus one");

    a_tunnel_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_in_tunnel
            == (o_dark_count >= $signed({1'b0, r_cfg.enter_threshold}))))
        else $error("tunnel flag does not match counter");

endmodule
